// ===== rtl/core/prlm_pkg.sv =====
// Package with the shared constants, types and state codes of the packet RMS level meter.
package prlm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 6;
  localparam int MAX_PACKET_DEF = 4096;
  localparam int QUEUE_DEPTH    = 2;

  // A squared 16-bit sample reaches 2^30 and needs 31 bits.
  localparam int SQ_W    = 2 * SAMPLE_W - 1;
  // Four times the mean square stays at or below 2^32.
  localparam int Q_W     = 2 * SAMPLE_W + 1;
  localparam int ROOT_W  = SAMPLE_W + 1;
  localparam int X_W     = 2 * ROOT_W;
  localparam int SREM_W  = ROOT_W + 3;
  localparam int LEVEL_W = ROOT_W;

  localparam logic [CFG_W-1:0] SAMPLE_BITS_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] SAMPLE_BITS_LEVEL = CFG_W'(16);

  typedef struct packed {
    logic silent;
    logic ovf;
  } job_flags_t;

  localparam int JOB_FLAGS_W = $bits(job_flags_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/core/prlm_in_if.sv =====
// Sample channel interface: valid/ready handshake carrying one sample and its packet marks.
interface prlm_in_if import prlm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_packet;
  logic                       packet_silent;

  modport source (output valid, output sample, output last_in_packet,
                  output packet_silent, input ready);
  modport sink   (input valid, input sample, input last_in_packet,
                  input packet_silent, output ready);
endinterface

// ===== rtl/core/prlm_out_if.sv =====
// Result channel interface: valid/ready handshake carrying one packet level.
interface prlm_out_if import prlm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               overflowed;

  modport source (output valid, output level, output overflowed, input ready);
  modport sink   (input valid, input level, input overflowed, output ready);
endinterface

// ===== rtl/core/prlm_front.sv =====
// Front end: accepts, squares and sums samples; one job per silent or width-16 packet.
module prlm_front import prlm_pkg::*; #(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int CNT_W      = $clog2(MAX_PACKET + 1),
  parameter int SUM_W      = SQ_W - 1 + CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  prlm_in_if.sink          in_chan,
  input  logic [CFG_W-1:0] sample_bits,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0] push_cnt,
  output job_flags_t       push_flags
);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_PACKET);

  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             s1_valid_r;
  logic [SQ_W-1:0]  s1_sq_r;
  logic             s1_last_r;
  logic             s1_silent_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_ovf_r;
  logic [SUM_W-1:0] acc_r;

  logic                     in_fire;
  logic                     counted;
  logic [CNT_W-1:0]         cnt_after;
  logic                     ovf_after;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SUM_W-1:0]         sum_now;
  logic                     emit;
  logic                     stall;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign counted   = cnt_r < MAX_C;
  assign cnt_after = counted ? cnt_r + CNT_W'(1) : cnt_r;
  assign ovf_after = ovf_r | ~counted;
  assign prod      = in_chan.sample * in_chan.sample;

  assign sum_now = acc_r + SUM_W'(s1_sq_r);
  // A non-silent packet at a sample width other than 16 closes without a result.
  assign emit    = s1_silent_r || (sample_bits == SAMPLE_BITS_LEVEL);
  assign stall   = s1_valid_r && s1_last_r && emit && !push_ready;

  assign in_chan.ready = !stall;

  assign push_valid        = s1_valid_r && s1_last_r && emit;
  assign push_sum          = sum_now;
  assign push_cnt          = s1_cnt_r;
  assign push_flags.silent = s1_silent_r;
  assign push_flags.ovf    = s1_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      if (in_fire) begin
        if (in_chan.last_in_packet) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= cnt_after;
          ovf_r <= ovf_after;
        end
      end
      if (!stall) begin
        s1_valid_r <= in_fire;
        if (s1_valid_r) begin
          acc_r <= s1_last_r ? '0 : sum_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_sq_r     <= counted ? prod[SQ_W-1:0] : '0;
      s1_last_r   <= in_chan.last_in_packet;
      s1_silent_r <= in_chan.packet_silent;
      s1_cnt_r    <= cnt_after;
      s1_ovf_r    <= ovf_after;
    end
  end

endmodule

// ===== rtl/core/prlm_queue.sv =====
// Short job queue between the accumulating front end and the level computation.
module prlm_queue import prlm_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  logic do_push;
  logic do_pop;

  assign push_ready = fill_r != FILL_W'(DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/prlm_back.sv =====
// Back end: divides four times the square sum by the count, takes the root, holds the result.
module prlm_back import prlm_pkg::*; #(
  parameter int CNT_W      = $clog2(MAX_PACKET_DEF + 1),
  parameter int SUM_W      = SQ_W - 1 + CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [SUM_W-1:0] job_sum,
  input  logic [CNT_W-1:0] job_cnt,
  input  job_flags_t       job_flags,
  prlm_out_if.source       out_chan
);

  // The dividend is four times the square sum.
  localparam int DD_W  = SUM_W + 2;
  localparam int CTR_W = $clog2(DD_W + 1);
  localparam logic [CTR_W-1:0] DIV_LAST  = CTR_W'(DD_W - 1);
  localparam logic [CTR_W-1:0] SQRT_LAST = CTR_W'(ROOT_W - 1);

  back_state_t        state_r, state_nxt;
  logic [CTR_W-1:0]   ctr_r, ctr_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [DD_W-1:0]    dq_r, dq_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [SREM_W-1:0]  srem_r, srem_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               ovf_r, ovf_nxt;

  logic [CNT_W:0]     div_shift;
  logic               div_ge;
  logic [SREM_W-1:0]  sqrt_shift;
  logic [SREM_W-1:0]  sqrt_trial;
  logic               sqrt_ge;

  assign div_shift  = {rem_r, dq_r[DD_W-1]};
  assign div_ge     = div_shift >= {1'b0, div_r};
  assign sqrt_shift = {srem_r[SREM_W-3:0], x_r[X_W-1:X_W-2]};
  assign sqrt_trial = SREM_W'({root_r, 2'b01});
  assign sqrt_ge    = sqrt_shift >= sqrt_trial;

  assign out_chan.valid      = state_r == BK_DONE;
  assign out_chan.level      = level_r;
  assign out_chan.overflowed = ovf_r;

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    x_nxt     = x_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    level_nxt = level_r;
    ovf_nxt   = ovf_r;
    job_ready = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_ready = 1'b1;
          ovf_nxt   = job_flags.ovf;
          if (job_flags.silent || job_cnt == '0) begin
            level_nxt = '0;
            state_nxt = BK_DONE;
          end else begin
            div_nxt   = job_cnt;
            rem_nxt   = '0;
            dq_nxt    = {job_sum, 2'b00};
            ctr_nxt   = '0;
            state_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        // Restoring division, one quotient bit per cycle; the quotient
        // shifts in where the dividend shifts out.
        rem_nxt = div_ge ? CNT_W'(div_shift - {1'b0, div_r}) : CNT_W'(div_shift);
        dq_nxt  = {dq_r[DD_W-2:0], div_ge};
        ctr_nxt = ctr_r + CTR_W'(1);
        if (ctr_r == DIV_LAST) begin
          x_nxt     = X_W'(dq_nxt[Q_W-1:0]);
          root_nxt  = '0;
          srem_nxt  = '0;
          ctr_nxt   = '0;
          state_nxt = BK_SQRT;
        end
      end
      BK_SQRT: begin
        // Digit-by-digit square root, one root bit per cycle.
        srem_nxt = sqrt_ge ? sqrt_shift - sqrt_trial : sqrt_shift;
        root_nxt = {root_r[ROOT_W-2:0], sqrt_ge};
        x_nxt    = {x_r[X_W-3:0], 2'b00};
        ctr_nxt  = ctr_r + CTR_W'(1);
        if (ctr_r == SQRT_LAST) begin
          level_nxt = root_nxt;
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_chan.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r   <= ctr_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    x_r     <= x_nxt;
    root_r  <= root_nxt;
    srem_r  <= srem_nxt;
    level_r <= level_nxt;
    ovf_r   <= ovf_nxt;
  end

endmodule

// ===== rtl/core/packet_rms_level_meter.sv =====
// Top level of the packet RMS level meter: configuration register, front end, job queue, back end.
// Samples are taken at one per cycle unless a packet closes on a full job queue; each is
// squared, registered and added to the packet's square sum. At the marked last sample the
// sum, count and flags move as one job into a two-entry queue, so sampling goes on while
// earlier packets are still being measured; a non-silent packet at a sample width other
// than 16 gives no job. The back end takes a job and runs a restoring divider, one bit per
// cycle, then a square root, one bit per cycle. Silent packets skip both units and report
// level 0. Packets shorter than the back end's work on a job can fill the queue, and then
// the sample input stalls.
module packet_rms_level_meter import prlm_pkg::*; #(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  prlm_in_if.sink     in_chan,
  prlm_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W  = $clog2(MAX_PACKET + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int DATA_W = SUM_W + CNT_W + JOB_FLAGS_W;

  logic [CFG_W-1:0]  sample_bits_r;
  logic              push_valid;
  logic              push_ready;
  logic [SUM_W-1:0]  push_sum;
  logic [CNT_W-1:0]  push_cnt;
  job_flags_t        push_flags;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;
  logic [SUM_W-1:0]  job_sum;
  logic [CNT_W-1:0]  job_cnt;
  job_flags_t        job_flags;

  // The only register sits at address 0, so the address does not take part in decoding.
  assign pready = 1'b1;
  assign prdata = {paddr, 24'd0, sample_bits_r} & 32'h0000_003F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bits_r <= SAMPLE_BITS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      sample_bits_r <= pwdata[CFG_W-1:0];
    end
  end

  prlm_front #(
    .MAX_PACKET (MAX_PACKET),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .sample_bits (sample_bits_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_sum    (push_sum),
    .push_cnt    (push_cnt),
    .push_flags  (push_flags)
  );

  prlm_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_sum, push_cnt, push_flags}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign job_sum   = pop_data[DATA_W-1 -: SUM_W];
  assign job_cnt   = pop_data[JOB_FLAGS_W +: CNT_W];
  assign job_flags = pop_data[JOB_FLAGS_W-1:0];

  prlm_back #(
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_sum   (job_sum),
    .job_cnt   (job_cnt),
    .job_flags (job_flags),
    .out_chan  (out_chan)
  );

endmodule

// ===== sim/packet_rms_level_meter_tb.sv =====
// Self-checking testbench of the packet RMS level meter: random packets, width settings, stalls.
module packet_rms_level_meter_tb;
  import prlm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES     = 12;
  localparam int          SETTLE_CYCLES    = 100;
  localparam int          STALL_LIMIT      = 4000;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          MAX_REPORTS      = 10;
  localparam int          MAX_PKT          = MAX_PACKET_DEF;
  localparam logic [63:0] FULL_SCALE_LEVEL = 64'd65536;
  localparam logic [1:0]  ADDR_SAMPLE_BITS = 2'd0;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       silent;
  } pcm_item_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               overflowed;
  } level_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prlm_in_if  in_chan ();
  prlm_out_if out_chan ();

  packet_rms_level_meter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Stimulus and expectations.
  pcm_item_t     pending_samples[$];
  level_result_t expected_levels[$];

  // Predictor state: the register copy and the running packet accumulators.
  logic [CFG_W-1:0] width_setting;
  logic [63:0]      square_acc;
  int               count_acc;
  logic             dropped_acc;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_ticket;
  int  hold_served;
  int  hold_left;
  bit  in_took;
  int  stall_cycles;
  int  mismatch_count;
  int  samples_taken;
  int  levels_checked;
  int  width_settings_run;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_mismatch(string what, longint exp_val, longint act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
    end
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic void clear_packet_acc();
    square_acc  = '0;
    count_acc   = 0;
    dropped_acc = 1'b0;
  endfunction

  // Accumulates one accepted sample and queues the packet level at an unmuted last sample.
  function automatic void predict_packet_level(pcm_item_t it);
    int            sq;
    logic [63:0]   mean_x4;
    logic [63:0]   root;
    level_result_t res;
    sq = int'(it.sample) * int'(it.sample);
    if (count_acc < MAX_PKT) begin
      square_acc += 64'(sq);
      count_acc++;
    end else begin
      dropped_acc = 1'b1;
    end
    if (!it.last) begin
      return;
    end
    res.overflowed = dropped_acc;
    res.level      = '0;
    if (!it.silent && width_setting != SAMPLE_BITS_LEVEL) begin
      clear_packet_acc();
      return;
    end
    if (!it.silent && count_acc != 0) begin
      mean_x4 = (square_acc << 2) / 64'(count_acc);
      root    = floor_sqrt(mean_x4);
      if (root > FULL_SCALE_LEVEL) begin
        root = FULL_SCALE_LEVEL;
      end
      res.level = root[LEVEL_W-1:0];
    end
    clear_packet_acc();
    expected_levels.insert(expected_levels.size(), res);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1:       return SAMPLE_W'(-$urandom_range(255));
      2:       return SAMPLE_W'($urandom_range(255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void push_sample(logic [SAMPLE_W-1:0] s, logic last, logic silent);
    pcm_item_t it;
    it.sample = s;
    it.last   = last;
    it.silent = silent;
    pending_samples.insert(pending_samples.size(), it);
  endfunction

  // Mostly short packets, now and then a longer one; the silent flag is set on some last samples.
  task automatic queue_random_packets(int n_items);
    int queued;
    int len;
    queued = 0;
    while (queued < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if (k == len - 1) begin
          push_sample(pick_sample(), 1'b1, $urandom_range(4) == 0);
        end else begin
          push_sample(pick_sample(), 1'b0, 1'($urandom_range(1)));
        end
      end
      queued += len;
    end
  endtask

  task automatic queue_directed();
    push_sample(16'h7FFF, 1'b1, 1'b0);
    push_sample(16'h8000, 1'b1, 1'b0);
    push_sample(16'h0000, 1'b1, 1'b0);
    push_sample(16'h0001, 1'b1, 1'b0);
    push_sample(16'hFFFF, 1'b1, 1'b0);
    push_sample(16'd100,  1'b0, 1'b0);
    push_sample(-16'sd200, 1'b0, 1'b1);
    push_sample(16'd300,  1'b1, 1'b0);
    // Loud samples in a packet flagged silent still give level zero.
    push_sample(16'h7FFF, 1'b0, 1'b0);
    push_sample(16'h8000, 1'b1, 1'b1);
    push_sample(16'h5555, 1'b0, 1'b1);
    push_sample(16'hAAAA, 1'b0, 1'b0);
    push_sample(16'h5555, 1'b0, 1'b0);
    push_sample(16'hAAAA, 1'b1, 1'b0);
    push_sample(16'h7FFF, 1'b0, 1'b0);
    push_sample(16'h8000, 1'b0, 1'b0);
    push_sample(16'h0000, 1'b1, 1'b0);
  endtask

  // Waits until every sample went in and every level came out, then lets the back end finish.
  task automatic settle();
    while (pending_samples.size() != 0 || in_chan.valid || expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_SAMPLE_BITS;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_sample_bits();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(width_setting)) begin
      note_mismatch("sample_bits readback", longint'(width_setting), longint'(rd));
    end
  endtask

  task automatic set_sample_bits(logic [CFG_W-1:0] bits);
    logic [31:0] rd;
    apb_access(1'b1, 32'(bits), rd);
    width_setting = bits;
    width_settings_run++;
    check_sample_bits();
  endtask

  // Posedge monitor: feeds the predictor with accepted samples and checks accepted levels.
  always @(posedge clk) begin
    level_result_t want;
    pcm_item_t     got;
    in_took = in_chan.valid && in_chan.ready;
    if (rst_n) begin
      if (in_took) begin
        got.sample = in_chan.sample;
        got.last   = in_chan.last_in_packet;
        got.silent = in_chan.packet_silent;
        samples_taken++;
        predict_packet_level(got);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_levels.size() == 0) begin
          note_mismatch("unexpected level transaction", -1, longint'(out_chan.level));
        end else begin
          want = expected_levels.pop_front();
          levels_checked++;
          if (out_chan.level !== want.level) begin
            note_mismatch("level", longint'(want.level), longint'(out_chan.level));
          end
          if (out_chan.overflowed !== want.overflowed) begin
            note_mismatch("overflowed", longint'(want.overflowed), longint'(out_chan.overflowed));
          end
        end
      end
    end
  end

  // Sample driver: offers the next pending sample once the current one is taken.
  always @(negedge clk) begin
    pcm_item_t it;
    if (rst_n && (!in_chan.valid || in_took)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_samples.pop_front();
        in_chan.valid          <= 1'b1;
        in_chan.sample         <= it.sample;
        in_chan.last_in_packet <= it.last;
        in_chan.packet_silent  <= it.silent;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Level receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_served != hold_ticket) begin
      hold_served    <= hold_ticket;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] width_steps[5];
    width_steps = '{6'd8, 6'd32, 6'd63, 6'd0, 6'd17};
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.sample         = '0;
    in_chan.last_in_packet = 1'b0;
    in_chan.packet_silent  = 1'b0;
    out_chan.ready         = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    width_setting          = SAMPLE_BITS_RESET;
    hold_ticket            = 0;
    hold_served            = 0;
    hold_left              = 0;
    stall_cycles           = 0;
    mismatch_count         = 0;
    samples_taken          = 0;
    levels_checked         = 0;
    width_settings_run     = 0;
    clear_packet_acc();
    send_idle_pct = 6;
    recv_idle_pct = 72;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    check_sample_bits();

    queue_directed();
    queue_random_packets(300);
    settle();

    // Widths other than 16 only let silent packets through.
    foreach (width_steps[i]) begin
      set_sample_bits(width_steps[i]);
      queue_random_packets(40);
      settle();
    end

    send_idle_pct = 72;
    recv_idle_pct = 6;
    set_sample_bits(SAMPLE_BITS_LEVEL);
    queue_random_packets(200);
    settle();

    // No idling: the receiver holds off while short packets pile up behind the job queue.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ticket++;
    queue_random_packets(60);
    queue_random_packets(150);
    settle();

    if (expected_levels.size() != 0) begin
      note_mismatch("levels never delivered", expected_levels.size(), 0);
    end
    $display("Covered %0d samples and %0d packet levels over %0d sample-width settings,",
             samples_taken, levels_checked, width_settings_run + 1);
    $display("including silent packets, muted widths and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
